@@ rtl/core/gdc_pkg.sv @@
`timescale 1ns / 1ps
package gdc_pkg;

  localparam int unsigned MaxYearDefault = 9999;
  localparam int unsigned YearW = 14;
  localparam int unsigned DayNumW = 25;
  localparam int unsigned DiffW = 23;
  localparam logic [21:0] DiffLimit = 22'h3FFFFF;

  localparam logic [1:0] CmdAdd = 2'd0;
  localparam logic [1:0] CmdSub = 2'd1;
  localparam logic [1:0] CmdCmp = 2'd2;
  localparam logic [1:0] CmdDiff = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBad = 2'd1;
  localparam logic [1:0] StSat = 2'd2;

  // days before month m in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd1: days_before = 9'd0;
      4'd2: days_before = 9'd31;
      4'd3: days_before = 9'd59;
      4'd4: days_before = 9'd90;
      4'd5: days_before = 9'd120;
      4'd6: days_before = 9'd151;
      4'd7: days_before = 9'd181;
      4'd8: days_before = 9'd212;
      4'd9: days_before = 9'd243;
      4'd10: days_before = 9'd273;
      4'd11: days_before = 9'd304;
      4'd12: days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2: month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      default: month_len = 5'd0;
    endcase
  endfunction

endpackage

@@ rtl/core/gregorian_date_calculator.sv @@
`timescale 1ns / 1ps
// gregorian date calculator
// structure: 8 register stages, a result is offered once its request has passed through all of them
// throughput: one request per cycle; the pipeline stalls only when the output stalls
// reset: rst_ni clears all stage valid bits at once, payload registers are not reset
// stages: validate, to day number, add/compare, 400-year split, century split,
// four-year split, year and day of year, month and day into the output register
module gregorian_date_calculator
  import gdc_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MaxYearDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], year_a[15:2], month_a[19:16], day_a[24:20], year_b[38:25],
  // month_b[42:39], day_b[47:43], offset_days[69:48], zero fill to 72 bits
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // res_year[13:0], res_month[17:14], res_day[22:18], a_greater[23], a_equal[24],
  // day_difference[47:25], status[49:48], zero fill to 56 bits
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned Stages = 8;

  // reciprocals for the constant divisions, exact over the ranges used here
  localparam logic [16:0] Recip25 = 17'd83887;       // x / 25 = (x * r) >> 21, x < 91180
  localparam logic [24:0] Recip146097 = 25'd30103606; // >> 42, any 25-bit day number
  localparam logic [15:0] Recip1461 = 16'd45934;     // >> 26, any 16-bit remainder

  // one global enable: the whole pipe advances unless the last stage is full and stalled
  logic adv;
  logic [Stages-1:0] v_q;
  assign adv = !v_q[Stages-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Stages-2:0], s_axis_tvalid};
    end
  end

  // input unpack
  logic [1:0] in_cmd;
  logic [13:0] in_ya, in_yb;
  logic [3:0] in_ma, in_mb;
  logic [4:0] in_da, in_db;
  logic [21:0] in_off;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_ya = s_axis_tdata[15:2];
  assign in_ma = s_axis_tdata[19:16];
  assign in_da = s_axis_tdata[24:20];
  assign in_yb = s_axis_tdata[38:25];
  assign in_mb = s_axis_tdata[42:39];
  assign in_db = s_axis_tdata[47:43];
  assign in_off = s_axis_tdata[69:48];

  function automatic logic [16:0] div25(input logic [16:0] x);
    logic [33:0] prod;
    prod = 34'(x) * 34'(Recip25);
    div25 = {4'd0, prod[33:21]};
  endfunction

  // divisible by 100 is divisible by 4 and 25, by 400 is by 16 and 25
  function automatic logic leap_of(input logic [16:0] y);
    logic [16:0] q;
    q = div25(y);
    leap_of = (y[1:0] == 2'd0) && ((q * 17'd25 != y) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                   input logic [4:0] d);
    logic lp;
    lp = leap_of({3'd0, y});
    date_ok = (y >= 14'd1) && ({18'd0, y} <= 32'(MAX_YEAR)) && (m >= 4'd1) &&
              (m <= 4'd12) && (d >= 5'd1) && (d <= month_len(m, lp));
  endfunction

  // stage 1: validate and replace
  logic [1:0] s1_cmd_q;
  logic [13:0] s1_ya_q, s1_yb_q;
  logic [3:0] s1_ma_q, s1_mb_q;
  logic [4:0] s1_da_q, s1_db_q;
  logic [21:0] s1_off_q;
  logic s1_bad_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic oka, okb;
      oka = date_ok(in_ya, in_ma, in_da);
      okb = date_ok(in_yb, in_mb, in_db) || !in_cmd[1];
      s1_cmd_q <= in_cmd;
      s1_ya_q <= oka ? in_ya : 14'd1;
      s1_ma_q <= oka ? in_ma : 4'd1;
      s1_da_q <= oka ? in_da : 5'd1;
      s1_yb_q <= okb ? in_yb : 14'd1;
      s1_mb_q <= okb ? in_mb : 4'd1;
      s1_db_q <= okb ? in_db : 5'd1;
      s1_off_q <= in_off;
      s1_bad_q <= !oka || !okb;
    end
  end

  // p / 100 is (p / 4) / 25 and p / 400 is (p / 16) / 25
  function automatic logic [DayNumW-1:0] to_days(input logic [13:0] y, input logic [3:0] m,
                                                 input logic [4:0] d);
    logic [13:0] p;
    logic [DayNumW-1:0] n;
    p = y - 14'd1;
    n = DayNumW'(p) * DayNumW'(365) + DayNumW'(p >> 2) -
        DayNumW'(div25({5'd0, p[13:2]})) + DayNumW'(div25({7'd0, p[13:4]}));
    n = n + DayNumW'(days_before(m)) + DayNumW'(d) - DayNumW'(1);
    if (m > 4'd2 && leap_of({3'd0, y})) n = n + DayNumW'(1);
    to_days = n;
  endfunction

  // day number of the last day of MAX_YEAR
  localparam logic [DayNumW-1:0] TopDay = DayNumW'(MAX_YEAR) * DayNumW'(365) +
      DayNumW'(MAX_YEAR / 4) - DayNumW'(MAX_YEAR / 100) +
      DayNumW'(MAX_YEAR / 400) - DayNumW'(1);

  // stage 2: day numbers
  logic [1:0] s2_cmd_q;
  logic [DayNumW-1:0] s2_na_q, s2_nb_q;
  logic [21:0] s2_off_q;
  logic s2_bad_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cmd_q <= s1_cmd_q;
      s2_na_q <= to_days(s1_ya_q, s1_ma_q, s1_da_q);
      s2_nb_q <= to_days(s1_yb_q, s1_mb_q, s1_db_q);
      s2_off_q <= s1_off_q;
      s2_bad_q <= s1_bad_q;
    end
  end

  // stage 3: add, subtract, compare, difference
  logic [1:0] s3_cmd_q;
  logic [DayNumW-1:0] s3_n_q;
  logic s3_gt_q, s3_eq_q, s3_sat_q, s3_bad_q;
  logic [DiffW-1:0] s3_diff_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [DayNumW:0] sum;
      logic [DayNumW-1:0] mag;
      logic ge;
      sum = {1'b0, s2_na_q} + (DayNumW + 1)'(s2_off_q);
      ge = s2_na_q >= s2_nb_q;
      mag = ge ? s2_na_q - s2_nb_q : s2_nb_q - s2_na_q;
      s3_cmd_q <= s2_cmd_q;
      s3_bad_q <= s2_bad_q;
      s3_gt_q <= (s2_cmd_q == CmdCmp) && (s2_na_q > s2_nb_q);
      s3_eq_q <= (s2_cmd_q == CmdCmp) && (s2_na_q == s2_nb_q);
      s3_n_q <= '0;
      s3_sat_q <= 1'b0;
      s3_diff_q <= '0;
      case (s2_cmd_q)
        CmdAdd: begin
          if (sum > (DayNumW + 1)'(TopDay)) begin
            s3_n_q <= TopDay;
            s3_sat_q <= 1'b1;
          end else begin
            s3_n_q <= sum[DayNumW-1:0];
          end
        end
        CmdSub: begin
          if (DayNumW'(s2_off_q) > s2_na_q) begin
            s3_sat_q <= 1'b1;
          end else begin
            s3_n_q <= s2_na_q - DayNumW'(s2_off_q);
          end
        end
        CmdDiff: begin
          logic [21:0] v;
          v = (mag > DayNumW'(DiffLimit)) ? DiffLimit : mag[21:0];
          s3_sat_q <= mag > DayNumW'(DiffLimit);
          s3_diff_q <= ge ? {1'b0, v} : DiffW'(0) - {1'b0, v};
        end
        default: ;
      endcase
    end
  end

  // fields that ride along unchanged behind the date split
  typedef struct packed {
    logic no_date;
    logic gt;
    logic eq;
    logic sat;
    logic bad;
    logic [DiffW-1:0] diff;
  } side_t;

  // stage 4: split off whole 400-year cycles
  logic [7:0] s4_q400_q;
  logic [17:0] s4_r_q;
  side_t s4_sd_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [49:0] prod;
      logic [7:0] q400;
      prod = 50'(s3_n_q) * 50'(Recip146097);
      q400 = prod[49:42];
      s4_q400_q <= q400;
      s4_r_q <= 18'(s3_n_q - DayNumW'(q400) * DayNumW'(146097));
      s4_sd_q <= '{no_date: s3_cmd_q[1], gt: s3_gt_q, eq: s3_eq_q, sat: s3_sat_q,
                   bad: s3_bad_q, diff: s3_diff_q};
    end
  end

  // stage 5: centuries, the last day of a 400-year cycle stays in the fourth
  logic [16:0] s5_ybase_q;
  logic [15:0] s5_r_q;
  side_t s5_sd_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [1:0] q100;
      q100 = (s4_r_q >= 18'd109572) ? 2'd3 :
             (s4_r_q >= 18'd73048) ? 2'd2 :
             (s4_r_q >= 18'd36524) ? 2'd1 : 2'd0;
      s5_ybase_q <= 17'(s4_q400_q) * 17'd400 + 17'(q100) * 17'd100;
      s5_r_q <= 16'(s4_r_q - 18'(q100) * 18'd36524);
      s5_sd_q <= s4_sd_q;
    end
  end

  // stage 6: 4-year cycles
  logic [16:0] s6_ybase_q;
  logic [10:0] s6_r_q;
  side_t s6_sd_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [31:0] prod;
      logic [5:0] q4;
      prod = 32'(s5_r_q) * 32'(Recip1461);
      q4 = prod[31:26];
      s6_ybase_q <= s5_ybase_q + 17'(q4) * 17'd4;
      s6_r_q <= 11'(s5_r_q - 16'(q4) * 16'd1461);
      s6_sd_q <= s5_sd_q;
    end
  end

  // stage 7: year within 4-year cycle, day of year
  logic [16:0] s7_y_q;
  logic [8:0] s7_doy_q;
  side_t s7_sd_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [1:0] q1;
      q1 = (s6_r_q >= 11'd1095) ? 2'd3 :
           (s6_r_q >= 11'd730) ? 2'd2 :
           (s6_r_q >= 11'd365) ? 2'd1 : 2'd0;
      s7_y_q <= s6_ybase_q + 17'(q1) + 17'd1;
      s7_doy_q <= 9'(s6_r_q - 11'(q1) * 11'd365);
      s7_sd_q <= s6_sd_q;
    end
  end

  // stage 8: month and day, output register
  logic [55:0] s8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic lp;
      logic [3:0] m;
      logic [8:0] st;
      logic [13:0] ry;
      logic [3:0] rm;
      logic [4:0] rd;
      logic [1:0] stt;
      lp = leap_of(s7_y_q);
      m = 4'd1;
      for (int k = 2; k <= 12; k++) begin
        st = days_before(4'(k)) + ((k > 2 && lp) ? 9'd1 : 9'd0);
        if (s7_doy_q >= st) m = 4'(k);
      end
      st = days_before(m) + ((m > 4'd2 && lp) ? 9'd1 : 9'd0);
      ry = s7_y_q[13:0];
      rm = m;
      rd = 5'(s7_doy_q - st + 9'd1);
      if (s7_sd_q.no_date) begin
        ry = '0;
        rm = '0;
        rd = '0;
      end
      stt = s7_sd_q.bad ? StBad : (s7_sd_q.sat ? StSat : StOk);
      s8_q <= {6'd0, stt, s7_sd_q.diff, s7_sd_q.eq, s7_sd_q.gt, rd, rm, ry};
    end
  end

  assign m_axis_tvalid = v_q[Stages-1];
  assign m_axis_tdata = s8_q;

endmodule

@@ rtl/core/gdc_checker.sv @@
`timescale 1ns / 1ps
module gdc_checker
  import gdc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // stalled output holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // input side is ready whenever the output is empty
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("not ready with empty output");

  // status never takes the unused code
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[49:48] <= StSat)
    else $error("bad status code");

  // greater and equal never both set
  a_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[23] && m_axis_tdata[24]))
    else $error("greater and equal both set");

endmodule

bind gregorian_date_calculator gdc_checker u_gdc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
